>>> hdl/csb_pkg.sv
package csb_pkg;

	localparam int unsigned S_DATA_W = 16;
	localparam int unsigned M_DATA_W = 24;
	localparam int unsigned ELEM_W   = 8;
	localparam int unsigned LEN_W    = 9;

	typedef enum logic [2:0] {
		OP_REWIND = 3'd0,
		OP_STEP   = 3'd1,
		OP_INS_L  = 3'd2,
		OP_INS_R  = 3'd3,
		OP_ERASE  = 3'd4,
		OP_READ   = 3'd5
	} csb_op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_BAD  = 2'd1,
		ST_FULL = 2'd2
	} csb_status_t;

	typedef struct packed {
		logic        take;
		logic        cur_zero;
		logic        cur_inc;
		logic        start_up;
		logic        ins_right;
		logic        start_down;
		logic        move_up;
		logic        move_down;
		logic        put_elem;
		logic        cnt_dec;
		logic        fetch;
		logic        load_out;
		csb_status_t status;
	} csb_cmd_t;

	typedef struct packed {
		logic at_stop;
		logic empty;
		logic full;
		logic up_more;
		logic down_more;
		logic wb_pending;
		logic out_free;
	} csb_stat_t;

endpackage

>>> hdl/csb_ctrl.sv
module csb_ctrl
	import csb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic [2:0] in_op,
	output logic      in_ready,
	input  csb_stat_t st,
	output csb_cmd_t  cmd
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_UP    = 5'b00010,
		S_DOWN  = 5'b00100,
		S_FETCH = 5'b01000,
		S_OUT   = 5'b10000
	} state_t;

	state_t      state_q, state_d;
	csb_status_t status_q, status_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d  = state_q;
		status_d = status_q;
		cmd      = '0;
		cmd.status = status_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					status_d = ST_OK;
					state_d  = S_FETCH;
					case (in_op)
						OP_REWIND: cmd.cur_zero = 1'b1;
						OP_STEP: begin
							if (st.at_stop) status_d = ST_BAD;
							else cmd.cur_inc = 1'b1;
						end
						OP_INS_L: begin
							if (st.full) begin
								status_d = ST_FULL;
							end else begin
								cmd.start_up = 1'b1;
								state_d      = S_UP;
							end
						end
						OP_INS_R: begin
							if (!st.empty && st.at_stop) begin
								status_d = ST_BAD;
							end else if (st.full) begin
								status_d = ST_FULL;
							end else begin
								cmd.start_up  = 1'b1;
								cmd.ins_right = 1'b1;
								state_d       = S_UP;
							end
						end
						OP_ERASE: begin
							if (st.at_stop) begin
								status_d = ST_BAD;
							end else begin
								cmd.start_down = 1'b1;
								state_d        = S_DOWN;
							end
						end
						OP_READ: begin
							if (st.at_stop) status_d = ST_BAD;
						end
						default: status_d = ST_BAD;
					endcase
				end
			end
			S_UP: begin
				// The last copy drains through the write-back stage before the new byte lands.
				if (st.up_more) begin
					cmd.move_up = 1'b1;
				end else if (!st.wb_pending) begin
					cmd.put_elem = 1'b1;
					state_d      = S_FETCH;
				end
			end
			S_DOWN: begin
				if (st.down_more) begin
					cmd.move_down = 1'b1;
				end else if (!st.wb_pending) begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_FETCH;
				end
			end
			S_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = S_OUT;
			end
			S_OUT: begin
				if (st.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			status_q <= ST_OK;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
		end
	end

endmodule

>>> hdl/csb_dp.sv
module csb_dp
	import csb_pkg::*;
#(
	parameter int unsigned CAPACITY = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  csb_cmd_t              cmd,
	input  logic [ELEM_W-1:0]     in_elem,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [M_DATA_W-1:0]   out_data,
	output csb_stat_t             st
);

	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned XW = CW + LEN_W;

	logic [ELEM_W-1:0] mem_q [CAPACITY];
	logic [ELEM_W-1:0] rdata_q;
	logic [ELEM_W-1:0] elem_q;
	logic [CW-1:0]     count_q, cursor_q, ptr_q, pos_q;
	logic              ins_right_q;
	logic              wb_valid_q;
	logic [AW-1:0]     wb_addr_q;
	logic              out_valid_q;
	logic [M_DATA_W-1:0] out_data_q;

	logic [CW-1:0] rd_idx;
	logic          rd_en;
	logic          stop_now;
	logic [XW-1:0] count_ext;

	assign stop_now  = (cursor_q >= count_q);
	assign count_ext = XW'(count_q);

	assign st.at_stop    = stop_now;
	assign st.empty      = (count_q == '0);
	assign st.full       = (count_q >= CW'(CAPACITY));
	assign st.up_more    = (ptr_q > pos_q);
	assign st.down_more  = (({1'b0, ptr_q} + (CW+1)'(1)) < {1'b0, count_q});
	assign st.wb_pending = wb_valid_q;
	assign st.out_free   = !out_valid_q || out_ready;

	always_comb begin
		if (cmd.move_up)        rd_idx = ptr_q - CW'(1);
		else if (cmd.move_down) rd_idx = ptr_q + CW'(1);
		else                    rd_idx = cursor_q;
	end
	assign rd_en = cmd.move_up || cmd.move_down || cmd.fetch;

	// Shifts copy one byte a cycle: read one neighbor, write it back in the next cycle.
	always_ff @(posedge clk) begin
		if (wb_valid_q) begin
			mem_q[wb_addr_q] <= rdata_q;
		end else if (cmd.put_elem) begin
			mem_q[pos_q[AW-1:0]] <= elem_q;
		end
		if (rd_en) begin
			rdata_q <= mem_q[rd_idx[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			elem_q <= in_elem;
		end
		if (cmd.start_up) begin
			ptr_q       <= count_q;
			ins_right_q <= cmd.ins_right;
			if (cmd.ins_right && count_q != '0) pos_q <= cursor_q + CW'(1);
			else                                 pos_q <= cursor_q;
		end else if (cmd.start_down) begin
			ptr_q <= cursor_q;
		end else if (cmd.move_up) begin
			ptr_q <= ptr_q - CW'(1);
		end else if (cmd.move_down) begin
			ptr_q <= ptr_q + CW'(1);
		end
		if (cmd.move_up || cmd.move_down) begin
			wb_addr_q <= ptr_q[AW-1:0];
		end
		if (cmd.load_out) begin
			out_data_q <= {{(M_DATA_W-22){1'b0}}, cmd.status, stop_now, (cursor_q == '0),
				count_ext[LEN_W-1:0], !stop_now, stop_now ? {ELEM_W{1'b0}} : rdata_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cursor_q    <= '0;
			wb_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			wb_valid_q <= cmd.move_up || cmd.move_down;
			if (cmd.cur_zero) begin
				cursor_q <= '0;
			end else if (cmd.cur_inc) begin
				cursor_q <= cursor_q + CW'(1);
			end else if (cmd.put_elem) begin
				cursor_q <= ins_right_q ? pos_q : cursor_q + CW'(1);
			end
			if (cmd.put_elem) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

>>> hdl/cursor_sequence_buffer.sv
// Rewind, step, read and rejected operations go from accept through the fetch and output
// states to the output register. Insert and erase first copy the bytes from the insert
// position or the cursor onward one byte per cycle through the store's single write port
// and wait for the write-back of the last copy before they fetch and output the result.
// One operation is in flight at a time; the next word is taken while a result waits.
// Reset (arst_n low) empties the sequence and puts the cursor at position zero.
module cursor_sequence_buffer
	import csb_pkg::*;
#(
	parameter int unsigned CAPACITY = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// operation[2:0], element[10:3], zero fill above
	input  logic [S_DATA_W-1:0] s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	// cursor_element[7:0], element_valid[8], sequence_length[17:9], at_start[18],
	// at_stop[19], status[21:20], zero fill above
	output logic [M_DATA_W-1:0] m_tdata
);

	csb_cmd_t  cmd;
	csb_stat_t st;

	csb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_op    (s_tdata[2:0]),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	csb_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_elem   (s_tdata[10:3]),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_data  (m_tdata),
		.st        (st)
	);

endmodule
